// ===== rtl/core/gpsp_pkg.sv =====
// Shared types, constants and helper functions of the position line parser.
package gpsp_pkg;

    localparam int FRAC_DIGITS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int INT_W   = 17;
    localparam int FRAC_W  = 20;
    localparam int CNT_W   = 3;
    localparam int ALT_W   = 21;
    localparam int MAG_W   = 35;
    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int QUOT_W  = 11;

    localparam logic [INT_W-1:0] INT_CAP = 17'd131071;
    localparam logic [ALT_W-1:0] ALT_CAP = 21'd2000000;
    localparam logic [ALT_W-1:0] ALT_POS_MAX = 21'd1000000;
    localparam logic [ALT_W-1:0] ALT_NEG_MAX = 21'd100000;
    localparam logic [MAG_W-1:0] LAT_MAX = 35'd900000000;
    localparam logic [MAG_W-1:0] LON_MAX = 35'd1800000000;

    // floor(x / 100) = (x * M100) >> 24, exact for every 17-bit x
    localparam logic [17:0] M100 = 18'd167773;
    localparam int M100_SHIFT = 24;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [3:0] PREFIX_LAST = 4'd9;

    // Raw fields of one finished response, handed from parser to converter.
    typedef struct packed {
        logic              parse_ok;
        logic [INT_W-1:0]  lat_int;
        logic [FRAC_W-1:0] lat_frac;
        logic [CNT_W-1:0]  lat_cnt;
        logic              south;
        logic [INT_W-1:0]  lon_int;
        logic [FRAC_W-1:0] lon_frac;
        logic [CNT_W-1:0]  lon_cnt;
        logic              west;
        logic [ALT_W-1:0]  alt_mag;
        logic              alt_neg;
    } raw_fix_t;

    // Flags that ride alongside the conversion pipeline.
    typedef struct packed {
        logic             parse_ok;
        logic             south;
        logic             west;
        logic [ALT_W-1:0] alt;
    } side_t;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h2B; // +
            4'd1:    ch = 8'h43; // C
            4'd2:    ch = 8'h47; // G
            4'd3:    ch = 8'h50; // P
            4'd4:    ch = 8'h53; // S
            4'd5:    ch = 8'h49; // I
            4'd6:    ch = 8'h4E; // N
            4'd7:    ch = 8'h46; // F
            4'd8:    ch = 8'h4F; // O
            4'd9:    ch = 8'h3A; // :
            default: ch = 8'h2B;
        endcase
        return ch;
    endfunction

    function automatic logic [FRAC_W-1:0] pow10_small(input logic [CNT_W-1:0] n);
        logic [FRAC_W-1:0] p;
        case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

    function automatic longint pow10_const(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    // Euclid by repeated subtraction; only used on elaboration constants.
    function automatic longint gcd_const(input longint a, input longint b);
        longint x;
        longint y;
        longint t;
        x = a;
        y = b;
        while (y != 0)
        begin
            while (x >= y)
            begin
                x = x - y;
            end
            t = x;
            x = y;
            y = t;
        end
        return x;
    endfunction

endpackage

// ===== rtl/core/gps_position_line_parser_core.sv =====
// Position line parser top level: parser front, response queue, converter back.
//
// Input channel: one response byte per item (char_in), with end_of_response high
// on the last byte. One byte is taken per cycle while in_stall is low.
// Output channel: one item per response, emitted after its last byte: new_fix says
// whether this response gave an accepted position; have_fix and fix_lat / fix_lon
// / fix_alt show the held fix (zero until the first one).
// Order: a response's item reaches out_valid through the queue write, which shares
// the edge that accepts its last byte, then five conversion stages and the output
// register.
// Throughput: one byte per cycle while unstalled; back-to-back one-byte responses
// also run at one per cycle while unstalled, set by the fully pipelined converter.
// Reset: clears the parser, the queue, the pipeline and the held fix.
// Out stall: the output register and converter hold; finished responses collect
// in the queue (QUEUE_DEPTH entries) and in_stall rises only when it is full.
module gps_position_line_parser_core #(
    parameter int FRAC_DIGITS = gpsp_pkg::FRAC_DIGITS_DEF,
    parameter int QUEUE_DEPTH = gpsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        char_in,
    input  logic                              end_of_response,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              new_fix,
    output logic                              have_fix,
    output logic signed [gpsp_pkg::LAT_W-1:0] fix_lat,
    output logic signed [gpsp_pkg::LON_W-1:0] fix_lon,
    output logic signed [gpsp_pkg::ALT_W-1:0] fix_alt
);

    logic               accept;
    logic               push;
    logic               pop;
    logic               q_empty;
    logic               q_full;
    gpsp_pkg::raw_fix_t rec;
    gpsp_pkg::raw_fix_t head;

    // Hold the byte stream while no queue slot is free for a finished response.
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    gpsp_front #(.FRAC_DIGITS(FRAC_DIGITS)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .char_in         (char_in),
        .end_of_response (end_of_response),
        .push            (push),
        .rec             (rec)
    );

    gpsp_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (rec),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    gpsp_back #(.FRAC_DIGITS(FRAC_DIGITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .new_fix   (new_fix),
        .have_fix  (have_fix),
        .fix_lat   (fix_lat),
        .fix_lon   (fix_lon),
        .fix_alt   (fix_alt)
    );

endmodule

// ===== rtl/core/gpsp_front.sv =====
// Character parser: prefix search, field syntax checks and raw field capture.
module gpsp_front #(
    parameter int FRAC_DIGITS = gpsp_pkg::FRAC_DIGITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         char_in,
    input  logic               end_of_response,
    output logic               push,
    output gpsp_pkg::raw_fix_t rec
);

    typedef enum logic [3:0] {
        PH_SEARCH, PH_LAT, PH_NS, PH_NS_REST, PH_LON, PH_EW, PH_EW_REST,
        PH_DATE, PH_TIME, PH_ALT, PH_DONE
    } phase_t;

    localparam logic [gpsp_pkg::CNT_W-1:0] FD = gpsp_pkg::CNT_W'(FRAC_DIGITS);

    phase_t phase_reg, phase_next;
    logic [3:0] match_reg, match_next;
    logic failed_reg, failed_next;
    logic seen_digit_reg, seen_digit_next;
    logic seen_point_reg, seen_point_next;
    logic alt_neg_reg, alt_neg_next;
    logic [gpsp_pkg::INT_W-1:0] int_reg, int_next;
    logic [gpsp_pkg::FRAC_W-1:0] frac_reg, frac_next;
    logic [gpsp_pkg::CNT_W-1:0] fcnt_reg, fcnt_next;
    logic [gpsp_pkg::ALT_W-1:0] alt_reg, alt_next;
    logic [gpsp_pkg::INT_W-1:0] lat_int_reg, lat_int_next, lon_int_reg, lon_int_next;
    logic [gpsp_pkg::FRAC_W-1:0] lat_frac_reg, lat_frac_next, lon_frac_reg, lon_frac_next;
    logic [gpsp_pkg::CNT_W-1:0] lat_cnt_reg, lat_cnt_next, lon_cnt_reg, lon_cnt_next;
    logic south_reg, south_next, west_reg, west_next;

    logic       is_digit;
    logic [3:0] digit;
    logic       lead_ok;
    logic [20:0] int_prod;
    logic [23:0] frac_prod;
    logic [24:0] alt_prod;
    logic [21:0] alt_sum;

    always_comb
    begin
        is_digit  = (char_in >= gpsp_pkg::CH_ZERO) && (char_in <= gpsp_pkg::CH_NINE);
        digit     = 4'(char_in - gpsp_pkg::CH_ZERO);
        lead_ok   = !seen_digit_reg && !seen_point_reg && !alt_neg_reg;
        int_prod  = 21'(int_reg) * 21'd10 + 21'(digit);
        frac_prod = 24'(frac_reg) * 24'd10 + 24'(digit);
        alt_prod  = 25'(alt_reg) * 25'd10 + 25'(digit) * 25'd10;
        alt_sum   = 22'(alt_reg) + 22'(digit);

        phase_next      = phase_reg;
        match_next      = match_reg;
        failed_next     = failed_reg;
        seen_digit_next = seen_digit_reg;
        seen_point_next = seen_point_reg;
        alt_neg_next    = alt_neg_reg;
        int_next        = int_reg;
        frac_next       = frac_reg;
        fcnt_next       = fcnt_reg;
        alt_next        = alt_reg;
        lat_int_next    = lat_int_reg;
        lat_frac_next   = lat_frac_reg;
        lat_cnt_next    = lat_cnt_reg;
        lon_int_next    = lon_int_reg;
        lon_frac_next   = lon_frac_reg;
        lon_cnt_next    = lon_cnt_reg;
        south_next      = south_reg;
        west_next       = west_reg;

        if (!failed_reg)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (char_in == gpsp_pkg::prefix_char(match_reg))
                    begin
                        match_next = match_reg + 4'd1;
                        if (match_reg == gpsp_pkg::PREFIX_LAST)
                        begin
                            phase_next = PH_LAT;
                        end
                    end
                    else
                    begin
                        match_next = (char_in == gpsp_pkg::CH_PLUS) ? 4'd1 : 4'd0;
                    end
                end
                PH_LAT, PH_LON:
                begin
                    if (char_in == gpsp_pkg::CH_SPACE && lead_ok)
                    begin
                        // leading blank: skip
                    end
                    else if (is_digit)
                    begin
                        seen_digit_next = 1'b1;
                        if (!seen_point_reg)
                        begin
                            int_next = (int_prod > 21'(gpsp_pkg::INT_CAP)) ?
                                       gpsp_pkg::INT_CAP : int_prod[gpsp_pkg::INT_W-1:0];
                        end
                        else if (fcnt_reg < FD)
                        begin
                            frac_next = frac_prod[gpsp_pkg::FRAC_W-1:0];
                            fcnt_next = fcnt_reg + 3'd1;
                        end
                    end
                    else if (char_in == gpsp_pkg::CH_POINT)
                    begin
                        if (seen_point_reg)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            seen_point_next = 1'b1;
                        end
                    end
                    else if (char_in == gpsp_pkg::CH_COMMA && seen_digit_reg)
                    begin
                        if (phase_reg == PH_LAT)
                        begin
                            lat_int_next  = int_reg;
                            lat_frac_next = frac_reg;
                            lat_cnt_next  = fcnt_reg;
                            phase_next    = PH_NS;
                        end
                        else
                        begin
                            lon_int_next  = int_reg;
                            lon_frac_next = frac_reg;
                            lon_cnt_next  = fcnt_reg;
                            phase_next    = PH_EW;
                        end
                        seen_digit_next = 1'b0;
                        seen_point_next = 1'b0;
                        int_next        = '0;
                        frac_next       = '0;
                        fcnt_next       = '0;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_NS:
                begin
                    if (char_in == gpsp_pkg::CH_N || char_in == gpsp_pkg::CH_S)
                    begin
                        south_next = (char_in == gpsp_pkg::CH_S);
                        phase_next = PH_NS_REST;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_EW:
                begin
                    if (char_in == gpsp_pkg::CH_E || char_in == gpsp_pkg::CH_W)
                    begin
                        west_next  = (char_in == gpsp_pkg::CH_W);
                        phase_next = PH_EW_REST;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_NS_REST:
                begin
                    if (char_in == gpsp_pkg::CH_COMMA) phase_next = PH_LON;
                end
                PH_EW_REST:
                begin
                    if (char_in == gpsp_pkg::CH_COMMA) phase_next = PH_DATE;
                end
                PH_DATE:
                begin
                    if (char_in == gpsp_pkg::CH_COMMA) phase_next = PH_TIME;
                end
                PH_TIME:
                begin
                    if (char_in == gpsp_pkg::CH_COMMA)
                    begin
                        phase_next      = PH_ALT;
                        seen_digit_next = 1'b0;
                        seen_point_next = 1'b0;
                        alt_neg_next    = 1'b0;
                        fcnt_next       = '0;
                        alt_next        = '0;
                    end
                end
                PH_ALT:
                begin
                    if (char_in == gpsp_pkg::CH_SPACE && lead_ok)
                    begin
                        // leading blank: skip
                    end
                    else if (char_in == gpsp_pkg::CH_MINUS && lead_ok)
                    begin
                        alt_neg_next = 1'b1;
                    end
                    else if (is_digit)
                    begin
                        seen_digit_next = 1'b1;
                        if (!seen_point_reg)
                        begin
                            alt_next = (alt_prod > 25'(gpsp_pkg::ALT_CAP)) ?
                                       gpsp_pkg::ALT_CAP : alt_prod[gpsp_pkg::ALT_W-1:0];
                        end
                        else if (fcnt_reg == '0)
                        begin
                            alt_next = (alt_sum > 22'(gpsp_pkg::ALT_CAP)) ?
                                       gpsp_pkg::ALT_CAP : alt_sum[gpsp_pkg::ALT_W-1:0];
                            fcnt_next = 3'd1;
                        end
                    end
                    else if (char_in == gpsp_pkg::CH_POINT)
                    begin
                        if (seen_point_reg)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            seen_point_next = 1'b1;
                        end
                    end
                    else if ((char_in == gpsp_pkg::CH_COMMA || char_in == gpsp_pkg::CH_CR ||
                              char_in == gpsp_pkg::CH_LF) && seen_digit_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        push         = accept && end_of_response;
        rec.parse_ok = !failed_next &&
                       (phase_next == PH_DONE || (phase_next == PH_ALT && seen_digit_next));
        rec.lat_int  = lat_int_next;
        rec.lat_frac = lat_frac_next;
        rec.lat_cnt  = lat_cnt_next;
        rec.south    = south_next;
        rec.lon_int  = lon_int_next;
        rec.lon_frac = lon_frac_next;
        rec.lon_cnt  = lon_cnt_next;
        rec.west     = west_next;
        rec.alt_mag  = alt_next;
        rec.alt_neg  = alt_neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEARCH;
            match_reg      <= '0;
            failed_reg     <= 1'b0;
            seen_digit_reg <= 1'b0;
            seen_point_reg <= 1'b0;
            alt_neg_reg    <= 1'b0;
            int_reg        <= '0;
            frac_reg       <= '0;
            fcnt_reg       <= '0;
            alt_reg        <= '0;
            lat_int_reg    <= '0;
            lat_frac_reg   <= '0;
            lat_cnt_reg    <= '0;
            lon_int_reg    <= '0;
            lon_frac_reg   <= '0;
            lon_cnt_reg    <= '0;
            south_reg      <= 1'b0;
            west_reg       <= 1'b0;
        end
        else if (accept && end_of_response)
        begin
            // response closed: start the next one from a clean parse
            phase_reg      <= PH_SEARCH;
            match_reg      <= '0;
            failed_reg     <= 1'b0;
            seen_digit_reg <= 1'b0;
            seen_point_reg <= 1'b0;
            alt_neg_reg    <= 1'b0;
            int_reg        <= '0;
            frac_reg       <= '0;
            fcnt_reg       <= '0;
            alt_reg        <= '0;
            lat_int_reg    <= '0;
            lat_frac_reg   <= '0;
            lat_cnt_reg    <= '0;
            lon_int_reg    <= '0;
            lon_frac_reg   <= '0;
            lon_cnt_reg    <= '0;
            south_reg      <= 1'b0;
            west_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            match_reg      <= match_next;
            failed_reg     <= failed_next;
            seen_digit_reg <= seen_digit_next;
            seen_point_reg <= seen_point_next;
            alt_neg_reg    <= alt_neg_next;
            int_reg        <= int_next;
            frac_reg       <= frac_next;
            fcnt_reg       <= fcnt_next;
            alt_reg        <= alt_next;
            lat_int_reg    <= lat_int_next;
            lat_frac_reg   <= lat_frac_next;
            lat_cnt_reg    <= lat_cnt_next;
            lon_int_reg    <= lon_int_next;
            lon_frac_reg   <= lon_frac_next;
            lon_cnt_reg    <= lon_cnt_next;
            south_reg      <= south_next;
            west_reg       <= west_next;
        end
    end

endmodule

// ===== rtl/core/gpsp_queue.sv =====
// Short queue of finished responses between parser and converter.
module gpsp_queue #(
    parameter int QUEUE_DEPTH = gpsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gpsp_pkg::raw_fix_t push_data,
    input  logic               pop,
    output gpsp_pkg::raw_fix_t head,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    gpsp_pkg::raw_fix_t slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    always_comb
    begin
        empty   = (cnt_reg == '0);
        full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
        do_push = push && !full;
        do_pop  = pop && !empty;
        head    = slot_reg[rd_reg];
        wr_next = do_push ? ((wr_reg == LAST) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next = do_pop ? ((rd_reg == LAST) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/gpsp_coord.sv =====
// Five-stage pipeline turning ddmm.frac into a 1e-7 degree magnitude.
module gpsp_coord #(
    parameter int FRAC_DIGITS = gpsp_pkg::FRAC_DIGITS_DEF
) (
    input  logic                               clk,
    input  logic                               advance,
    input  logic [gpsp_pkg::INT_W-1:0]         ip,
    input  logic [gpsp_pkg::FRAC_W-1:0]        fp,
    input  logic [gpsp_pkg::CNT_W-1:0]         cnt,
    output logic [gpsp_pkg::MAG_W-1:0]         mag
);

    // minutes/60 scaled to 1e-7 deg reduces to floor(mins * K / D)
    localparam longint KR = gpsp_pkg::pow10_const(7 - FRAC_DIGITS);
    localparam longint G  = gpsp_pkg::gcd_const(KR, 60);
    localparam longint K  = KR / G;
    localparam longint D  = 60 / G;
    localparam longint RK = 10000000 / G;
    localparam longint MD = ((64'd1 << 32) + D - 1) / D;
    localparam logic [gpsp_pkg::CNT_W-1:0] FD = gpsp_pkg::CNT_W'(FRAC_DIGITS);

    logic [34:0] q_prod;
    logic [39:0] f_prod;
    logic [gpsp_pkg::CNT_W-1:0] sh;
    logic [58:0] d_prod;

    logic [gpsp_pkg::QUOT_W-1:0] q1_reg, q2_reg, q3_reg;
    logic [gpsp_pkg::INT_W-1:0]  ip1_reg;
    logic [gpsp_pkg::FRAC_W-1:0] f1_reg;
    logic [6:0]                  rem2_reg;
    logic [26:0]                 fk2_reg;
    logic [26:0]                 x3_reg;
    logic [24:0]                 frac4_reg;
    logic [gpsp_pkg::MAG_W-1:0]  deg4_reg, mag5_reg;

    always_comb
    begin
        sh     = (cnt > FD) ? '0 : FD - cnt;
        q_prod = 35'(ip) * 35'(gpsp_pkg::M100);
        f_prod = 40'(fp) * 40'(gpsp_pkg::pow10_small(sh));
        d_prod = 59'(x3_reg) * 59'(MD);
        mag    = mag5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q1_reg    <= q_prod[gpsp_pkg::M100_SHIFT +: gpsp_pkg::QUOT_W];
            ip1_reg   <= ip;
            f1_reg    <= f_prod[gpsp_pkg::FRAC_W-1:0];
            rem2_reg  <= 7'(ip1_reg - 17'(q1_reg) * 17'd100);
            fk2_reg   <= 27'(27'(f1_reg) * 27'(K));
            q2_reg    <= q1_reg;
            x3_reg    <= 27'(27'(rem2_reg) * 27'(RK)) + fk2_reg;
            q3_reg    <= q2_reg;
            frac4_reg <= d_prod[56:32];
            deg4_reg  <= 35'(q3_reg) * 35'd10000000;
            mag5_reg  <= deg4_reg + 35'(frac4_reg);
        end
    end

endmodule

// ===== rtl/core/gpsp_back.sv =====
// Converter side: coordinate pipelines, range checks, held fix and output register.
module gpsp_back #(
    parameter int FRAC_DIGITS = gpsp_pkg::FRAC_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gpsp_pkg::raw_fix_t              head,
    input  logic                            q_empty,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            new_fix,
    output logic                            have_fix,
    output logic signed [gpsp_pkg::LAT_W-1:0] fix_lat,
    output logic signed [gpsp_pkg::LON_W-1:0] fix_lon,
    output logic signed [gpsp_pkg::ALT_W-1:0] fix_alt
);

    localparam int STAGES = 5;

    logic advance;
    logic [STAGES-1:0] vld_reg;
    gpsp_pkg::side_t side_reg [STAGES];
    gpsp_pkg::side_t side_in;
    logic [gpsp_pkg::MAG_W-1:0] lat_mag, lon_mag;
    logic commit;
    logic out_valid_reg, new_fix_reg, held_valid_reg;
    logic [gpsp_pkg::LAT_W-1:0] held_lat_reg;
    logic [gpsp_pkg::LON_W-1:0] held_lon_reg;
    logic [gpsp_pkg::ALT_W-1:0] held_alt_reg, alt_sat;

    gpsp_coord #(.FRAC_DIGITS(FRAC_DIGITS)) u_lat (
        .clk     (clk),
        .advance (advance),
        .ip      (head.lat_int),
        .fp      (head.lat_frac),
        .cnt     (head.lat_cnt),
        .mag     (lat_mag)
    );

    gpsp_coord #(.FRAC_DIGITS(FRAC_DIGITS)) u_lon (
        .clk     (clk),
        .advance (advance),
        .ip      (head.lon_int),
        .fp      (head.lon_frac),
        .cnt     (head.lon_cnt),
        .mag     (lon_mag)
    );

    always_comb
    begin
        advance = !out_valid_reg || !out_stall;
        pop     = advance && !q_empty;
        if (head.alt_neg)
        begin
            alt_sat = (head.alt_mag > gpsp_pkg::ALT_NEG_MAX) ? gpsp_pkg::ALT_NEG_MAX
                                                            : head.alt_mag;
            alt_sat = -alt_sat;
        end
        else
        begin
            alt_sat = (head.alt_mag > gpsp_pkg::ALT_POS_MAX) ? gpsp_pkg::ALT_POS_MAX
                                                            : head.alt_mag;
        end
        side_in.parse_ok = head.parse_ok;
        side_in.south    = head.south;
        side_in.west     = head.west;
        side_in.alt      = alt_sat;
        commit = vld_reg[STAGES-1] && side_reg[STAGES-1].parse_ok &&
                 !(lat_mag == '0 && lon_mag == '0) &&
                 (lat_mag <= gpsp_pkg::LAT_MAX) && (lon_mag <= gpsp_pkg::LON_MAX);
        out_valid = out_valid_reg;
        new_fix   = new_fix_reg;
        have_fix  = held_valid_reg;
        fix_lat   = held_lat_reg;
        fix_lon   = held_lon_reg;
        fix_alt   = held_alt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            new_fix_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            held_lat_reg   <= '0;
            held_lon_reg   <= '0;
            held_alt_reg   <= '0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[STAGES-2:0], !q_empty};
            out_valid_reg <= vld_reg[STAGES-1];
            new_fix_reg   <= commit;
            if (commit)
            begin
                // replace the held fix with this response's position
                held_valid_reg <= 1'b1;
                held_lat_reg   <= side_reg[STAGES-1].south ?
                                  -lat_mag[gpsp_pkg::LAT_W-1:0] : lat_mag[gpsp_pkg::LAT_W-1:0];
                held_lon_reg   <= side_reg[STAGES-1].west ?
                                  -lon_mag[gpsp_pkg::LON_W-1:0] : lon_mag[gpsp_pkg::LON_W-1:0];
                held_alt_reg   <= side_reg[STAGES-1].alt;
            end
        end
    end

endmodule

// ===== rtl/core/gpsp_checker.sv =====
// Port-level checks of the position line parser, bound to the top level.
module gpsp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              new_fix,
    input logic                              have_fix,
    input logic signed [gpsp_pkg::LAT_W-1:0] fix_lat,
    input logic signed [gpsp_pkg::LON_W-1:0] fix_lon,
    input logic signed [gpsp_pkg::ALT_W-1:0] fix_alt
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_fix) && $stable(fix_lat) &&
        $stable(fix_lon) && $stable(fix_alt))
        else $error("output item changed while stalled");

    a_new_has: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_fix |-> have_fix)
        else $error("new fix reported without a held fix");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !have_fix |-> fix_lat == '0 && fix_lon == '0 && fix_alt == '0)
        else $error("position nonzero with no fix held");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && have_fix |->
        fix_lat >= -31'sd900000000 && fix_lat <= 31'sd900000000 &&
        fix_lon >= -32'sd1800000000 && fix_lon <= 32'sd1800000000 &&
        fix_alt >= -21'sd100000 && fix_alt <= 21'sd1000000)
        else $error("held fix out of range");

endmodule

bind gps_position_line_parser_core gpsp_checker u_gpsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_fix   (new_fix),
    .have_fix  (have_fix),
    .fix_lat   (fix_lat),
    .fix_lon   (fix_lon),
    .fix_alt   (fix_alt)
);

// ===== tb/gps_position_line_parser_core_tb.sv =====
// Testbench for the position line parser: directed and random responses vs a predictor.
`timescale 1ns / 100ps

module gps_position_line_parser_core_tb;

    localparam int FRAC_N = gpsp_pkg::FRAC_DIGITS_DEF;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int ITEM_BUDGET = 1850;
    localparam int DIR_N = 22;

    // parse phases of the predictor
    typedef enum int {
        P_SEARCH, P_LAT, P_NS, P_NS_REST, P_LON, P_EW, P_EW_REST,
        P_DATE, P_TIME, P_ALT, P_DONE
    } phase_t;

    typedef struct packed {
        logic                              new_fix;
        logic                              have_fix;
        logic signed [gpsp_pkg::LAT_W-1:0] lat;
        logic signed [gpsp_pkg::LON_W-1:0] lon;
        logic signed [gpsp_pkg::ALT_W-1:0] alt;
    } fix_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] char_in = 8'h00;
    logic end_of_response = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic new_fix;
    logic have_fix;
    logic signed [gpsp_pkg::LAT_W-1:0] fix_lat;
    logic signed [gpsp_pkg::LON_W-1:0] fix_lon;
    logic signed [gpsp_pkg::ALT_W-1:0] fix_alt;

    always #2 clk = ~clk;

    gps_position_line_parser_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .char_in(char_in), .end_of_response(end_of_response),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_fix(new_fix), .have_fix(have_fix),
        .fix_lat(fix_lat), .fix_lon(fix_lon), .fix_alt(fix_alt)
    );

    // predictor state
    int unsigned match_cnt;
    phase_t      phase;
    bit          failed;
    longint unsigned acc_int, acc_frac, acc_cnt, acc_alt;
    bit          got_digit, got_point, neg_alt;
    longint unsigned lat_i, lat_f, lat_c, lon_i, lon_f, lon_c;
    bit          is_south, is_west;
    logic [gpsp_pkg::LAT_W-1:0] hold_lat;
    logic [gpsp_pkg::LON_W-1:0] hold_lon;
    logic [gpsp_pkg::ALT_W-1:0] hold_alt;
    bit          hold_ok;

    fix_report_t pending_reports[$];
    bit          any_fail = 1'b0;
    longint      cycles = 0;

    string prefix_str = "+CGPSINFO:";

    // directed stimulus table; expected new_fix typed in where obvious, -1 means predictor only
    string dir_text [DIR_N] = '{
        "+CGPSINFO:,,,,,,,,",
        "+CGPSINFO:4807.038,N,01131.000,E,230394,123519.0,545.4",
        "+CGPSINFO:9000.0,S,18000.0,W,0,0,-99999",
        "+CGPSINFO:9000.1,N,00100.0,E,0,0,1",
        "+CGPSINFO:0000.0,N,18000.1,E,0,0,1",
        "+CGPSINFO:0000.000,N,00000.00,E,0,0,5",
        "+CGPSINFO:  1234.5678901,S,  01259.99,W,x,y, -12.34\r\n",
        "+CGPSINFO:1299.9,N,12399.9,E,d,t,99999999,1\r\nOK",
        "+CGPSINFO:1234.5,Nxx,01234.5,Eyy,d,t,-9999999.9",
        "+CGPSINFO:999999,N,1,E,d,t,1",
        "+CGPSINFO:12.3.4,N,1,E,d,t,1",
        "+CGPSINFO:1 2,N,1,E,d,t,1",
        "+CGPSINFO:12,X,1,E,d,t,1",
        "+CGPSINFO:12,N,1,Q,d,t,1",
        "+CGPSINFO:12,N,1,E,d,t,",
        "+CGPSINFO:12,N,1,E,d,t,--1",
        "+CGPSINFO:12,N,1,E,d",
        "++CG+CGPSINFO:1200,N,0100,E,d,t,.5,+CGPSINFO:x",
        "+CGPSINF+CGPSINFO:4500,N,4500,E,d,t,0.",
        "+CGPSINFO:4575.5,N,00099.999999,E,d,t,.",
        "\377\200+CGPSINFO:0100,N,0100,E,d,t,7",
        "Z"
    };
    int dir_new [DIR_N] = '{
        0, 1, 1, 0, 0, 0, -1, -1, -1, 0, 0,
        0, 0, 0, 0, 0, 0, -1, 1, 0, 1, 0
    };

    function automatic void clear_field();
        acc_int = 0; acc_frac = 0; acc_cnt = 0;
        got_digit = 0; got_point = 0; neg_alt = 0;
    endfunction

    function automatic void clear_line();
        clear_field();
        match_cnt = 0; phase = P_SEARCH; failed = 0;
        lat_i = 0; lat_f = 0; lat_c = 0; lon_i = 0; lon_f = 0; lon_c = 0;
        is_south = 0; is_west = 0; acc_alt = 0;
    endfunction

    function automatic longint unsigned p10(longint unsigned n);
        longint unsigned p = 1;
        for (int i = 0; i < n; i++) p = p * 10;
        return p;
    endfunction

    // -1 fail, 0 continue, 1 field closed
    function automatic int coord_byte(logic [7:0] c);
        if (c == gpsp_pkg::CH_SPACE && !got_digit && !got_point) return 0;
        if (c >= gpsp_pkg::CH_ZERO && c <= gpsp_pkg::CH_NINE)
        begin
            got_digit = 1;
            if (!got_point)
            begin
                acc_int = acc_int * 10 + (c - gpsp_pkg::CH_ZERO);
                if (acc_int > gpsp_pkg::INT_CAP) acc_int = gpsp_pkg::INT_CAP;
            end
            else if (acc_cnt < FRAC_N)
            begin
                acc_frac = acc_frac * 10 + (c - gpsp_pkg::CH_ZERO);
                acc_cnt++;
            end
            return 0;
        end
        if (c == gpsp_pkg::CH_POINT)
        begin
            if (got_point) return -1;
            got_point = 1;
            return 0;
        end
        if (c == gpsp_pkg::CH_COMMA) return got_digit ? 1 : -1;
        return -1;
    endfunction

    function automatic int alt_byte(logic [7:0] c);
        if (c == gpsp_pkg::CH_SPACE && !got_digit && !got_point && !neg_alt) return 0;
        if (c == gpsp_pkg::CH_MINUS && !got_digit && !got_point && !neg_alt)
        begin
            neg_alt = 1;
            return 0;
        end
        if (c >= gpsp_pkg::CH_ZERO && c <= gpsp_pkg::CH_NINE)
        begin
            got_digit = 1;
            if (!got_point)
            begin
                acc_alt = acc_alt * 10 + (c - gpsp_pkg::CH_ZERO) * 10;
                if (acc_alt > gpsp_pkg::ALT_CAP) acc_alt = gpsp_pkg::ALT_CAP;
            end
            else if (acc_cnt == 0)
            begin
                acc_alt = acc_alt + (c - gpsp_pkg::CH_ZERO);
                if (acc_alt > gpsp_pkg::ALT_CAP) acc_alt = gpsp_pkg::ALT_CAP;
                acc_cnt = 1;
            end
            return 0;
        end
        if (c == gpsp_pkg::CH_POINT)
        begin
            if (got_point) return -1;
            got_point = 1;
            return 0;
        end
        if (c == gpsp_pkg::CH_COMMA || c == gpsp_pkg::CH_CR || c == gpsp_pkg::CH_LF)
            return got_digit ? 1 : -1;
        return -1;
    endfunction

    function automatic longint unsigned degrees_e7(longint unsigned ip, longint unsigned fp,
                                                   longint unsigned cnt);
        longint unsigned p, f, mins;
        p = p10(FRAC_N);
        f = fp * p10(cnt > FRAC_N ? 0 : FRAC_N - cnt);
        mins = (ip % 100) * p + f;
        return (ip / 100) * 10000000 + (mins * 10000000) / (60 * p);
    endfunction

    function automatic bit store_fix();
        longint unsigned la, lo, a;
        la = degrees_e7(lat_i, lat_f, lat_c);
        lo = degrees_e7(lon_i, lon_f, lon_c);
        if (la == 0 && lo == 0) return 0;
        if (la > gpsp_pkg::LAT_MAX || lo > gpsp_pkg::LON_MAX) return 0;
        hold_lat = is_south ? -la[gpsp_pkg::LAT_W-1:0] : la[gpsp_pkg::LAT_W-1:0];
        hold_lon = is_west ? -lo[gpsp_pkg::LON_W-1:0] : lo[gpsp_pkg::LON_W-1:0];
        a = acc_alt;
        if (neg_alt)
        begin
            if (a > gpsp_pkg::ALT_NEG_MAX) a = gpsp_pkg::ALT_NEG_MAX;
            hold_alt = -a[gpsp_pkg::ALT_W-1:0];
        end
        else
        begin
            if (a > gpsp_pkg::ALT_POS_MAX) a = gpsp_pkg::ALT_POS_MAX;
            hold_alt = a[gpsp_pkg::ALT_W-1:0];
        end
        hold_ok = 1;
        return 1;
    endfunction

    function automatic void parse_byte(logic [7:0] c);
        int r;
        if (failed) return;
        case (phase)
            P_SEARCH:
            begin
                if (c == prefix_str[match_cnt])
                begin
                    match_cnt++;
                    if (match_cnt >= 10)
                    begin
                        phase = P_LAT;
                        clear_field();
                    end
                end
                else
                begin
                    match_cnt = (c == gpsp_pkg::CH_PLUS) ? 1 : 0;
                end
            end
            P_LAT, P_LON:
            begin
                r = coord_byte(c);
                if (r < 0) failed = 1;
                else if (r > 0)
                begin
                    if (phase == P_LAT)
                    begin
                        lat_i = acc_int; lat_f = acc_frac; lat_c = acc_cnt;
                        phase = P_NS;
                    end
                    else
                    begin
                        lon_i = acc_int; lon_f = acc_frac; lon_c = acc_cnt;
                        phase = P_EW;
                    end
                    clear_field();
                end
            end
            P_NS:
            begin
                if (c == gpsp_pkg::CH_N || c == gpsp_pkg::CH_S)
                begin
                    is_south = (c == gpsp_pkg::CH_S);
                    phase = P_NS_REST;
                end
                else failed = 1;
            end
            P_EW:
            begin
                if (c == gpsp_pkg::CH_E || c == gpsp_pkg::CH_W)
                begin
                    is_west = (c == gpsp_pkg::CH_W);
                    phase = P_EW_REST;
                end
                else failed = 1;
            end
            P_NS_REST: if (c == gpsp_pkg::CH_COMMA) phase = P_LON;
            P_EW_REST: if (c == gpsp_pkg::CH_COMMA) phase = P_DATE;
            P_DATE:    if (c == gpsp_pkg::CH_COMMA) phase = P_TIME;
            P_TIME:
            begin
                if (c == gpsp_pkg::CH_COMMA)
                begin
                    phase = P_ALT;
                    clear_field();
                    acc_alt = 0;
                end
            end
            P_ALT:
            begin
                r = alt_byte(c);
                if (r < 0) failed = 1;
                else if (r > 0) phase = P_DONE;
            end
            default: ;
        endcase
    endfunction

    // advance the predictor by one accepted item; queue the report on end of response
    function automatic void predict_item(logic [7:0] c, logic eor);
        fix_report_t rep;
        bit ok;
        ok = 0;
        parse_byte(c);
        if (eor)
        begin
            if (!failed && (phase == P_DONE || (phase == P_ALT && got_digit))) ok = store_fix();
            clear_line();
            rep.new_fix = ok;
            rep.have_fix = hold_ok;
            rep.lat = hold_lat;
            rep.lon = hold_lon;
            rep.alt = hold_alt;
            pending_reports.push_back(rep);
        end
    endfunction

    // stimulus: a list of responses, each a string; the last byte carries end_of_response
    string resp_list[$];
    int    typed_new[$];

    function automatic string rnd_digits(int n);
        string s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(gpsp_pkg::CH_ZERO + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rnd_coord(int ideg);
        string s = "";
        int nsp = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < nsp; i++) s = {s, " "};
        s = {s, rnd_digits(ideg + 2)};
        if ($urandom_range(0, 5) != 0) s = {s, ".", rnd_digits($urandom_range(0, 8))};
        return s;
    endfunction

    function automatic string rnd_noise(int n);
        string s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 255)))};
        return s;
    endfunction

    function automatic string rnd_response();
        string s, alt;
        int kind = $urandom_range(0, 19);
        int pos;
        alt = {($urandom_range(0, 3) == 0) ? "-" : "", rnd_digits($urandom_range(1, 7))};
        if ($urandom_range(0, 1)) alt = {alt, ".", rnd_digits($urandom_range(0, 3))};
        s = {($urandom_range(0, 3) == 0) ? "\r\n+CG" : "", "+CGPSINFO:",
             rnd_coord(2), ",", $urandom_range(0, 1) ? "N" : "S", ",",
             rnd_coord(3), ",", $urandom_range(0, 1) ? "E" : "W", ",",
             rnd_digits(6), ",", rnd_digits(6), ".0,", alt};
        case ($urandom_range(0, 3))
            0: s = {s, ",0.0,0\r\n\r\nOK\r\n"};
            1: s = {s, "\r\n"};
            default: ;
        endcase
        if (kind < 3)
        begin
            // break it at a random spot with a random byte
            pos = $urandom_range(0, s.len() - 1);
            s[pos] = 8'($urandom_range(0, 255));
        end
        else if (kind < 5)
        begin
            s = s.substr(0, $urandom_range(0, s.len() - 1));
        end
        else if (kind == 5)
        begin
            s = rnd_noise($urandom_range(1, 12));
        end
        return s;
    endfunction

    initial
    begin
        int total;
        string r;
        total = 0;
        // walk the directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            resp_list.push_back(dir_text[i]);
            typed_new.push_back(dir_new[i]);
            total += dir_text[i].len();
        end
        // random part: stop near the byte budget
        while (total < ITEM_BUDGET)
        begin
            r = rnd_response();
            resp_list.push_back(r);
            typed_new.push_back(-1);
            total += r.len();
        end
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: stall on its own pattern, sometimes long stretches free
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= (cycles % 7) < 5;
        endcase
    end

    // checker: compare each accepted report with the oldest expectation
    int typed_q[$];
    always @(posedge clk)
    begin
        fix_report_t exp_rep;
        int tn;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report with nothing pending");
                any_fail = 1'b1;
            end
            else
            begin
                exp_rep = pending_reports.pop_front();
                tn = typed_q.pop_front();
                if (tn >= 0 && exp_rep.new_fix != tn[0])
                begin
                    $error("new_fix typed expected %0d predicted %0d", tn, exp_rep.new_fix);
                    any_fail = 1'b1;
                end
                if (new_fix !== exp_rep.new_fix)
                begin
                    $error("new_fix expected %0d actual %0d", exp_rep.new_fix, new_fix);
                    any_fail = 1'b1;
                end
                if (have_fix !== exp_rep.have_fix)
                begin
                    $error("have_fix expected %0d actual %0d", exp_rep.have_fix, have_fix);
                    any_fail = 1'b1;
                end
                if (fix_lat !== exp_rep.lat)
                begin
                    $error("fix_lat expected %0d actual %0d", exp_rep.lat, fix_lat);
                    any_fail = 1'b1;
                end
                if (fix_lon !== exp_rep.lon)
                begin
                    $error("fix_lon expected %0d actual %0d", exp_rep.lon, fix_lon);
                    any_fail = 1'b1;
                end
                if (fix_alt !== exp_rep.alt)
                begin
                    $error("fix_alt expected %0d actual %0d", exp_rep.alt, fix_alt);
                    any_fail = 1'b1;
                end
            end
        end
    end

    // sender: bursts with random gaps; hold the item until accepted
    initial
    begin
        int burst;
        string r;
        int idx;
        int drain;
        hold_ok = 0; hold_lat = '0; hold_lon = '0; hold_alt = '0;
        clear_line();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst = $urandom_range(1, 40);
        for (idx = 0; idx < resp_list.size(); idx++)
        begin
            r = resp_list[idx];
            for (int b = 0; b < r.len(); b++)
            begin
                if (burst == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                    burst = $urandom_range(1, 40);
                end
                in_valid <= 1'b1;
                char_in <= r[b];
                end_of_response <= (b == r.len() - 1);
                @(posedge clk);
                while (in_stall) @(posedge clk);
                predict_item(r[b], b == r.len() - 1);
                if (b == r.len() - 1) typed_q.push_back(typed_new[idx]);
                burst--;
            end
        end
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        // let any stray report surface
        drain = 0;
        while (drain < 30)
        begin
            @(posedge clk);
            drain++;
        end
        if (!any_fail)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
